@@ design/pnl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnl_pkg
// Shared types, constants and fixed-point helpers for the PID / plant loop.
// ----------------------------------------------------------------------------
package pnl_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned SETTLE_BAND_DEF     = 6554;

  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANT_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANT_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANT_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANT_D  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_Q0   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_Q1   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_Q2   = 3'd7;

  localparam logic signed [31:0] SETPOINT_RST = 32'sd1310720;
  localparam logic signed [31:0] PLANT_A_RST  = 32'sd32768;
  localparam logic signed [31:0] PLANT_B_RST  = 32'sd39322;
  localparam logic signed [31:0] PLANT_C_RST  = 32'sd39322;
  localparam logic signed [31:0] PLANT_D_RST  = 32'sd39322;
  localparam logic signed [31:0] PID_Q0_RST   = 32'sd100091;
  localparam logic signed [31:0] PID_Q1_RST   = -32'sd95325;
  localparam logic signed [31:0] PID_Q2_RST   = 32'sd47662;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [31:0] OUT_RST     = 32'sd131072;
  localparam logic signed [31:0] ERR_RST     = 32'sd1179648;
  localparam logic signed [31:0] INV2PI_Q32  = 32'sd683565276;
  localparam logic [63:0]        HALFPI_Q30  = 64'd1686629713;
  localparam logic signed [63:0] ROUND_HALF  = 64'sd32768;

  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'd8;

  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       run;
    logic [3:0] cnt;
    logic       commit;
    logic [1:0] kind;
  } dp_cmd_t;

  typedef struct packed {
    logic act;
    logic banded;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [49:0] v);
    return (v > 50'sd2147483647) || (v < -50'sd2147483648);
  endfunction

  // Taylor sine on [0, pi/2], Q30 in and out
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    return unsigned'(sum);
  endfunction

endpackage
`default_nettype wire

@@ design/pnl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnl_if
// Valid/ready channels for loop commands and loop results.
// ----------------------------------------------------------------------------
interface pnl_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] start_value;
  modport source (output valid, action, start_value, input ready);
  modport sink   (input valid, action, start_value, output ready);
endinterface

interface pnl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] plant_output;
  logic signed [31:0] error_value;
  logic signed [31:0] control_value;
  logic               settled;
  logic               saturated;
  modport source (output valid, plant_output, error_value, control_value, settled,
                  saturated, input ready);
  modport sink   (input valid, plant_output, error_value, control_value, settled,
                  saturated, output ready);
endinterface
`default_nettype wire

@@ design/pnl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnl_ctrl
// Sequencer: capture, evaluate, nine run steps (normal tick only), commit to output reg.
// ----------------------------------------------------------------------------
module pnl_ctrl import pnl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [1:0] kind, kind_next;
  logic       can_commit;

  assign in_ready   = (state == ST_IDLE);
  assign can_commit = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    kind_next   = kind;
    cmd         = '0;
    cmd.cnt     = cnt;
    cmd.kind    = kind;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cnt_next = '0;
        if (sts.act) begin
          kind_next  = KIND_RESTART;
          state_next = ST_COMMIT;
        end else if (sts.banded) begin
          kind_next  = KIND_HOLD;
          state_next = ST_COMMIT;
        end else begin
          kind_next  = KIND_TICK;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = ST_COMMIT;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_COMMIT: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      kind      <= KIND_TICK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      kind  <= kind_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/pnl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnl_dp
// Datapath: config and loop state, shared 32x32 multiplier, sine table.
// ----------------------------------------------------------------------------
module pnl_dp import pnl_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned SETTLE_BAND     = SETTLE_BAND_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_action,
  input  wire logic signed [31:0]   in_start_value,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  output logic signed [31:0]        plant_output,
  output logic signed [31:0]        error_value,
  output logic signed [31:0]        control_value,
  output logic                      settled,
  output logic                      saturated
);

  localparam int unsigned B       = SINE_TABLE_BITS;
  localparam int unsigned QUARTER = 1 << (B - 2);

  typedef logic signed [31:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t       t;
    logic [63:0] th;
    logic [63:0] s;
    for (int j = 0; j <= QUARTER; j++) begin
      th   = (64'(j) * HALFPI_Q30) / QUARTER;
      s    = (sin_q30(th) + 64'd8192) >> 14;
      t[j] = s[31:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic signed [31:0] setpoint, plant_a, plant_b, plant_c, plant_d;
  logic signed [31:0] pid_q0, pid_q1, pid_q2;
  logic signed [31:0] out_last, out_before, err_last, err_before, ctrl_prev;
  logic               act;
  logic signed [31:0] start_value;
  logic signed [31:0] e_reg, u_reg, sine_val;
  logic signed [34:0] acc_u, acc_y;
  logic               flag;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a, mul_b;
  logic               mul_en, acc_en;
  logic [2:0]         mul_idx, acc_idx;
  logic signed [63:0] prod_rnd;
  logic signed [31:0] mq;
  logic               mq_ovf;
  logic [B:0]         sidx_w;
  logic [B-1:0]       sidx;
  logic [1:0]         quad;
  logic [B-3:0]       qr;
  logic [B-2:0]       qj;
  logic signed [31:0] smag;
  logic signed [49:0] e_wide, er_wide;
  logic signed [31:0] e_sat, er_sat, y_sat;
  logic               e_ovf, er_ovf, y_ovf;
  logic signed [31:0] band_in;
  logic signed [32:0] bdiff;
  logic [32:0]        babs;
  logic               band_hit;

  function automatic logic in_band(input logic signed [31:0] v,
                                   input logic signed [31:0] sp);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = 33'(v) - 33'(sp);
    m = d[32] ? unsigned'(-d) : unsigned'(d);
    return m <= 33'(SETTLE_BAND);
  endfunction

  assign mul_en  = cmd.run && (cmd.cnt < LAST_STEP);
  assign acc_en  = cmd.run && (cmd.cnt != 4'd0);
  assign mul_idx = cmd.cnt[2:0];
  assign acc_idx = 3'(cmd.cnt - 4'd1);

  always_comb begin
    case (mul_idx)
      3'd0:    begin mul_a = pid_q0;    mul_b = e_reg;      end
      3'd1:    begin mul_a = pid_q1;    mul_b = err_last;   end
      3'd2:    begin mul_a = pid_q2;    mul_b = err_before; end
      3'd3:    begin mul_a = ctrl_prev; mul_b = INV2PI_Q32; end
      3'd4:    begin mul_a = plant_a;   mul_b = out_last;   end
      3'd5:    begin mul_a = plant_b;   mul_b = out_before; end
      3'd6:    begin mul_a = plant_d;   mul_b = sine_val;   end
      default: begin mul_a = plant_c;   mul_b = u_reg;      end
    endcase
  end

  assign prod_rnd = prod + ROUND_HALF;
  assign mq       = sat32(50'(signed'(prod_rnd[63:16])));
  assign mq_ovf   = ovf32(50'(signed'(prod_rnd[63:16])));

  // wrap angle to one turn, round to table index, fold into quarter wave
  assign sidx_w = prod[47:47-B] + (B+1)'(1);
  assign sidx   = sidx_w[B:1];
  assign quad   = sidx[B-1:B-2];
  assign qr     = sidx[B-3:0];
  assign qj     = quad[0] ? (B-1)'(QUARTER) - (B-1)'(qr) : (B-1)'(qr);
  assign smag   = QTAB[qj];

  assign e_wide  = 50'(setpoint) - 50'(out_last);
  assign e_sat   = sat32(e_wide);
  assign e_ovf   = ovf32(e_wide);
  assign er_wide = 50'(setpoint) - 50'(start_value);
  assign er_sat  = sat32(er_wide);
  assign er_ovf  = ovf32(er_wide);
  assign y_sat   = sat32(50'(acc_y));
  assign y_ovf   = ovf32(50'(acc_y));

  assign band_in  = (cmd.kind == KIND_RESTART) ? start_value : y_sat;
  assign bdiff    = 33'(band_in) - 33'(setpoint);
  assign babs     = bdiff[32] ? unsigned'(-bdiff) : unsigned'(bdiff);
  assign band_hit = babs <= 33'(SETTLE_BAND);

  assign sts.act    = act;
  assign sts.banded = in_band(out_last, setpoint);

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= SETPOINT_RST;
      plant_a    <= PLANT_A_RST;
      plant_b    <= PLANT_B_RST;
      plant_c    <= PLANT_C_RST;
      plant_d    <= PLANT_D_RST;
      pid_q0     <= PID_Q0_RST;
      pid_q1     <= PID_Q1_RST;
      pid_q2     <= PID_Q2_RST;
      out_last   <= OUT_RST;
      out_before <= OUT_RST;
      err_last   <= ERR_RST;
      err_before <= ERR_RST;
      ctrl_prev  <= ONE_Q16;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SETPOINT: setpoint <= cfg_data;
          CFG_PLANT_A:  plant_a  <= cfg_data;
          CFG_PLANT_B:  plant_b  <= cfg_data;
          CFG_PLANT_C:  plant_c  <= cfg_data;
          CFG_PLANT_D:  plant_d  <= cfg_data;
          CFG_PID_Q0:   pid_q0   <= cfg_data;
          CFG_PID_Q1:   pid_q1   <= cfg_data;
          CFG_PID_Q2:   pid_q2   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && cmd.kind == KIND_RESTART) begin
        out_last   <= start_value;
        out_before <= start_value;
        err_last   <= er_sat;
        err_before <= er_sat;
        ctrl_prev  <= ONE_Q16;
      end else if (cmd.commit && cmd.kind == KIND_TICK) begin
        out_last   <= y_sat;
        out_before <= out_last;
        err_last   <= e_reg;
        err_before <= err_last;
        ctrl_prev  <= u_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act         <= in_action;
      start_value <= in_start_value;
    end
    if (cmd.eval) begin
      e_reg <= e_sat;
      flag  <= e_ovf;
      acc_u <= 35'(ctrl_prev);
      acc_y <= '0;
    end
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (acc_en) begin
      if (acc_idx != 3'd3) begin
        flag <= flag | mq_ovf;
      end
      case (acc_idx)
        3'd0, 3'd1, 3'd2: acc_u <= acc_u + 35'(mq);
        3'd3: begin
          sine_val <= quad[1] ? -smag : smag;
          u_reg    <= sat32(50'(acc_u));
          flag     <= flag | ovf32(50'(acc_u));
        end
        3'd5:    acc_y <= acc_y - 35'(mq);
        default: acc_y <= acc_y + 35'(mq);
      endcase
    end
    if (cmd.commit) begin
      case (cmd.kind)
        KIND_RESTART: begin
          plant_output  <= start_value;
          error_value   <= er_sat;
          control_value <= ONE_Q16;
          settled       <= band_hit;
          saturated     <= er_ovf;
        end
        KIND_HOLD: begin
          plant_output  <= out_last;
          error_value   <= err_last;
          control_value <= ctrl_prev;
          settled       <= 1'b1;
          saturated     <= 1'b0;
        end
        default: begin
          plant_output  <= y_sat;
          error_value   <= e_reg;
          control_value <= u_reg;
          settled       <= band_hit;
          saturated     <= flag | y_ovf;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/pid_nonlinear_plant_loop_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_nonlinear_plant_loop_step
// Velocity-form PID step driving a nonlinear second-order plant, Q16.16.
// A restart or settled tick goes accept, evaluate, commit; a normal tick adds
// the run steps, as the eight products share one registered 32x32 multiplier.
// One transaction is in flight at a time. Results are held in an output
// register, so a new transaction is taken while the last one waits.
// Sync reset restores registers and loop state to their defaults, no sweep.
// ----------------------------------------------------------------------------
module pid_nonlinear_plant_loop_step import pnl_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned SETTLE_BAND     = SETTLE_BAND_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  pnl_in_if.sink                    in_ch,
  pnl_out_if.source                 out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pnl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pnl_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SETTLE_BAND     (SETTLE_BAND)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (in_ch.action),
    .in_start_value (in_ch.start_value),
    .cmd            (cmd),
    .sts            (sts),
    .plant_output   (out_ch.plant_output),
    .error_value    (out_ch.error_value),
    .control_value  (out_ch.control_value),
    .settled        (out_ch.settled),
    .saturated      (out_ch.saturated)
  );

  a_no_ready_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready high during transaction");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd.kind == KIND_HOLD) |=> (out_ch.settled && !out_ch.saturated))
    else $error("settled hold result wrong");

  a_restart_ctrl: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd.kind == KIND_RESTART) |=> (out_ch.control_value == ONE_Q16))
    else $error("restart control not 1.0");

  a_run_idle_in: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> !in_ch.ready)
    else $error("input taken during run");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the PID / nonlinear plant loop step against a bit-exact loop model
// in the bench: restarts, ticks, settled holds and saturation are driven under
// several register settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import pnl_pkg::*;

  localparam int  LIMIT     = 600000;
  localparam int  TAB_N     = 1 << SINE_TABLE_BITS_DEF;
  localparam longint BAND   = SETTLE_BAND_DEF;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] e;
    logic signed [31:0] u;
    logic               settled;
    logic               sat;
  } loop_res_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] start_value;
  } loop_cmd_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pnl_in_if  in_ch ();
  pnl_out_if out_ch ();

  pid_nonlinear_plant_loop_step uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  loop_cmd_t pending_q[$];
  loop_res_t want_q[$];
  int        errors = 0;
  int        cycles = 0;

  longint cfg_reg [8];
  longint y_last, y_before, e_last, e_before, u_prev;
  longint sine_tab [TAB_N];

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint clip(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, inout bit f);
    longint p;
    p = a * b + 32768;
    return clip(p >>> 16, f);
  endfunction

  function automatic longint unsigned taylor_sin(longint unsigned x);
    longint unsigned x2, term;
    longint          acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  function automatic void fill_sine();
    int quarter, quad, r, j;
    longint unsigned th;
    longint s;
    quarter = TAB_N / 4;
    for (int i = 0; i < TAB_N; i++) begin
      quad = i / quarter;
      r    = i - quad * quarter;
      j    = (quad % 2 == 1) ? quarter - r : r;
      th   = (longint'(j) * 64'd1686629713) / quarter;
      s    = longint'((taylor_sin(th) + 8192) >> 14);
      sine_tab[i] = (quad >= 2) ? -s : s;
    end
  endfunction

  function automatic longint sine_of(longint x);
    longint unsigned fr, idx;
    fr  = longint'(x * 64'sd683565276) & ((64'd1 << 48) - 1);
    idx = ((fr >> (48 - SINE_TABLE_BITS_DEF - 1)) + 1) >> 1;
    return sine_tab[idx % TAB_N];
  endfunction

  function automatic bit near_setpoint(longint y);
    longint d;
    d = y - cfg_reg[CFG_SETPOINT];
    if (d < 0) d = -d;
    return d <= BAND;
  endfunction

  function automatic void loop_defaults();
    cfg_reg[CFG_SETPOINT] = SETPOINT_RST;
    cfg_reg[CFG_PLANT_A]  = PLANT_A_RST;
    cfg_reg[CFG_PLANT_B]  = PLANT_B_RST;
    cfg_reg[CFG_PLANT_C]  = PLANT_C_RST;
    cfg_reg[CFG_PLANT_D]  = PLANT_D_RST;
    cfg_reg[CFG_PID_Q0]   = PID_Q0_RST;
    cfg_reg[CFG_PID_Q1]   = PID_Q1_RST;
    cfg_reg[CFG_PID_Q2]   = PID_Q2_RST;
    y_last = 131072; y_before = 131072;
    e_last = 1179648; e_before = 1179648;
    u_prev = 65536;
  endfunction

  function automatic loop_res_t loop_step(loop_cmd_t c);
    loop_res_t r;
    bit f, st;
    longint e, u, y, s;
    f = 0;
    e = e_last;
    if (c.action) begin
      s = c.start_value;
      y_last = s; y_before = s;
      e = clip(cfg_reg[CFG_SETPOINT] - s, f);
      e_last = e; e_before = e;
      u_prev = 65536;
      st = near_setpoint(s);
    end else if (near_setpoint(y_last)) begin
      st = 1;
    end else begin
      e = clip(cfg_reg[CFG_SETPOINT] - y_last, f);
      u = clip(u_prev + qmul(cfg_reg[CFG_PID_Q0], e, f) + qmul(cfg_reg[CFG_PID_Q1], e_last, f)
               + qmul(cfg_reg[CFG_PID_Q2], e_before, f), f);
      y = clip(qmul(cfg_reg[CFG_PLANT_A], y_last, f) - qmul(cfg_reg[CFG_PLANT_B], y_before, f)
               + qmul(cfg_reg[CFG_PLANT_C], u, f)
               + qmul(cfg_reg[CFG_PLANT_D], sine_of(u_prev), f), f);
      e_before = e_last; e_last = e;
      y_before = y_last; y_last = y;
      u_prev = u;
      st = near_setpoint(y);
    end
    r.y = y_last[31:0];
    r.e = e[31:0];
    r.u = u_prev[31:0];
    r.settled = st;
    r.sat = f;
    return r;
  endfunction

  // gaps: mostly short, a few long, with calm stretches of none
  bit calm = 0;
  function automatic int gap_len();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int src_gap = 0;
  always @(posedge clk) begin
    loop_cmd_t c;
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        c.action = in_ch.action;
        c.start_value = in_ch.start_value;
        want_q = {want_q, loop_step(c)};
        nv = 1'b0;
        if ($urandom_range(0, 63) == 0) calm = ~calm;
        src_gap = gap_len();
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_q.size() > 0) begin
          c = pending_q.pop_front();
          in_ch.action <= c.action;
          in_ch.start_value <= c.start_value;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  int sink_gap = 0;
  always @(posedge clk) begin
    loop_res_t w;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (want_q.size() == 0) begin
          report("result with none pending");
        end else begin
          w = want_q.pop_front();
          if (out_ch.plant_output !== w.y)
            report($sformatf("plant_output %0d want %0d", out_ch.plant_output, w.y));
          if (out_ch.error_value !== w.e)
            report($sformatf("error_value %0d want %0d", out_ch.error_value, w.e));
          if (out_ch.control_value !== w.u)
            report($sformatf("control_value %0d want %0d", out_ch.control_value, w.u));
          if (out_ch.settled !== w.settled)
            report($sformatf("settled %0b want %0b", out_ch.settled, w.settled));
          if (out_ch.saturated !== w.sat)
            report($sformatf("saturated %0b want %0b", out_ch.saturated, w.sat));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        sink_gap = gap_len();
        out_ch.ready <= (sink_gap == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(bit act, logic [31:0] sv);
    loop_cmd_t c;
    c.action = act;
    c.start_value = sv;
    pending_q = {pending_q, c};
  endtask

  task automatic write_regs(longint vals [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i][31:0];
      cfg_reg[i] = longint'(signed'(vals[i][31:0]));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (!(pending_q.size() == 0 && !in_ch.valid && want_q.size() == 0)) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 5))
      0, 1: return 32'(cfg_reg[CFG_SETPOINT] + $signed($urandom_range(0, 1310720)) - 655360);
      2: return $urandom;
      3: return 32'($signed($urandom_range(0, 1048576)) - 524288);
      4: return 32'(cfg_reg[CFG_SETPOINT] + $signed($urandom_range(0, 13108)) - 6554);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic random_part(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) < 8) begin
        push_cmd(1'b1, pick_start());
        k++;
        repeat ($urandom_range(3, 30)) begin
          push_cmd(1'b0, $urandom);
          k++;
        end
      end else begin
        push_cmd(1'($urandom_range(0, 1)), $urandom);
        k++;
      end
    end
  endtask

  initial begin
    longint v [8];
    in_ch.valid = 0;
    in_ch.action = 0;
    in_ch.start_value = '0;
    out_ch.ready = 0;
    fill_sine();
    loop_defaults();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: ticks from reset state, start extremes, settled restart and hold
    repeat (4) push_cmd(1'b0, 32'h0);
    push_cmd(1'b1, 32'h7fffffff);
    repeat (3) push_cmd(1'b0, 32'hffffffff);
    push_cmd(1'b1, 32'h80000000);
    repeat (3) push_cmd(1'b0, 32'h0);
    push_cmd(1'b1, 32'h0);
    push_cmd(1'b1, SETPOINT_RST);
    push_cmd(1'b0, 32'h12345678);
    push_cmd(1'b1, SETPOINT_RST + 6554);
    push_cmd(1'b1, SETPOINT_RST - 6555);
    repeat (8) push_cmd(1'b0, 32'h0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: v = '{SETPOINT_RST, PLANT_A_RST, PLANT_B_RST, PLANT_C_RST, PLANT_D_RST,
                 PID_Q0_RST, PID_Q1_RST, PID_Q2_RST};
        1: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        2: v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000};
        3: v = '{0, 0, 0, 0, 0, 0, 0, 0};
        4: v = '{-655360, PLANT_A_RST, PLANT_B_RST, PLANT_C_RST, PLANT_D_RST,
                 PID_Q0_RST, PID_Q1_RST, PID_Q2_RST};
        5: for (int i = 0; i < 8; i++) v[i] = $urandom;
        default: begin
          v[0] = $signed($urandom_range(0, 2621440)) - 1310720;
          for (int i = 1; i < 8; i++) v[i] = $signed($urandom_range(0, 131072)) - 65536;
        end
      endcase
      write_regs(v);
      random_part((ph == 0 || ph >= 4) ? 230 : 90);
      drain();
    end

    while (want_q.size() > 0) begin
      void'(want_q.pop_front());
      report("result never arrived");
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
